>>> sv/itaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

  typedef enum logic [1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_word_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        hex;
    logic        upper;
    logic        neg;
    logic [31:0] mag;
  } job_t;

  localparam int VALUE_BITS = 32;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int QDEPTH     = 2;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_UPPER = 8'h41;

  // ascii for one hex nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CH_UPPER : CH_LOWER;
      if (nib < 4'd10) begin
        hex_char = CH_ZERO + {4'b0000, nib};
      end else begin
        hex_char = base + {4'b0000, nib} - 8'd10;
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/itaf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module itaf_front (
  input  var itaf_pkg::in_word_t item,
  output var itaf_pkg::job_t     job
);

  logic neg;

  always_comb begin
    neg       = (item.operation == itaf_pkg::OP_SDEC) && item.value[31];
    job.hex   = (item.operation == itaf_pkg::OP_HEXL) ||
                (item.operation == itaf_pkg::OP_HEXU);
    job.upper = (item.operation == itaf_pkg::OP_HEXU);
    job.neg   = neg;
    // two's complement magnitude, 0x80000000 stays 0x80000000
    job.mag   = neg ? (32'd0 - item.value) : item.value;
  end

endmodule

`default_nettype wire

>>> sv/itaf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module itaf_queue (
  input  var logic                clk,
  input  var logic                rst,
  input  var logic                wr,
  input  var itaf_pkg::job_t      wr_job,
  output var logic                full,
  input  var logic                rd,
  output var itaf_pkg::job_t      rd_job,
  output var logic                empty
);

  localparam int PW = $clog2(itaf_pkg::QDEPTH);

  itaf_pkg::job_t              slots [itaf_pkg::QDEPTH];
  logic [PW-1:0]               wr_ptr;
  logic [PW-1:0]               rd_ptr;
  logic [PW:0]                 count;
  logic                        do_wr;
  logic                        do_rd;

  assign full   = (count == (PW+1)'(itaf_pkg::QDEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/itaf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module itaf_back (
  input  var logic                 clk,
  input  var logic                 rst,
  input  var itaf_pkg::job_t       job,
  input  var logic                 job_empty,
  output var logic                 job_pop,
  output var logic                 empty,
  input  var logic                 pop,
  output var itaf_pkg::out_word_t  result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DABBLE,
    S_LEAD,
    S_EMIT
  } state_t;

  localparam int BCD_BITS = 4 * itaf_pkg::DEC_DIGITS;

  state_t                state;
  logic [BCD_BITS-1:0]   bcd;
  logic [31:0]           sh;
  logic [4:0]            bitcnt;
  logic [3:0]            pos;
  logic                  hex;
  logic                  upper;
  logic                  sign_pending;
  logic                  out_valid;

  logic [BCD_BITS-1:0]   adj;
  logic [3:0]            lead;
  logic [3:0]            dec_digit;
  logic [3:0]            hex_nib;
  logic                  out_free;
  logic                  emit;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // highest nonzero digit, zero gives digit 0
  always_comb begin
    lead = '0;
    for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        lead = 4'(i);
      end
    end
  end

  assign dec_digit = bcd[{pos, 2'b00} +: 4];
  assign hex_nib   = sh[{pos[2:0], 2'b00} +: 4];
  assign out_free  = !out_valid || pop;
  assign emit      = (state == S_EMIT) && out_free;
  assign job_pop   = (state == S_IDLE) && !job_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      sign_pending <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!job_empty) begin
            sh     <= job.mag;
            hex    <= job.hex;
            upper  <= job.upper;
            bcd    <= '0;
            bitcnt <= '0;
            if (job.hex) begin
              sign_pending <= 1'b0;
              pos          <= 4'(itaf_pkg::HEX_DIGITS - 1);
              state        <= S_EMIT;
            end else begin
              sign_pending <= job.neg;
              state        <= S_DABBLE;
            end
          end
        end
        S_DABBLE: begin
          bcd    <= {adj[BCD_BITS-2:0], sh[31]};
          sh     <= {sh[30:0], 1'b0};
          bitcnt <= bitcnt + 5'd1;
          if (bitcnt == 5'(itaf_pkg::VALUE_BITS - 1)) begin
            state <= S_LEAD;
          end
        end
        S_LEAD: begin
          pos   <= lead;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (sign_pending) begin
              result.character <= itaf_pkg::CH_MINUS;
              result.last      <= 1'b0;
              sign_pending     <= 1'b0;
            end else begin
              result.character <= hex ? itaf_pkg::hex_char(hex_nib, upper)
                                      : itaf_pkg::CH_ZERO + {4'b0000, dec_digit};
              result.last      <= (pos == 4'd0);
              pos              <= pos - 4'd1;
              if (pos == 4'd0) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none

// Formats a 32-bit value as ASCII text, one character per result word, most
// significant digit first, with last set on the final character. operation
// picks unsigned decimal, signed decimal (leading '-' on negative values),
// or eight-digit hex in lower or upper case. Input words are classified and
// held in a two-entry queue, so up to two values can be pushed ahead of the
// converter. A hex value is loaded and then emitted one digit at a time; a
// decimal value is loaded, converted from binary to bcd one bit per cycle,
// scanned for its leading digit and then emitted one character at a time.
// Characters leave at one per cycle while pop stays high.
module integer_to_ascii_formatter (
  input  var logic                 clk,
  input  var logic                 rst,
  input  var logic                 push,
  output var logic                 full,
  input  var itaf_pkg::in_word_t   item,
  output var logic                 empty,
  input  var logic                 pop,
  output var itaf_pkg::out_word_t  result
);

  itaf_pkg::job_t front_job;
  itaf_pkg::job_t back_job;
  logic           q_empty;
  logic           q_pop;

  itaf_front u_front (
    .item (item),
    .job  (front_job)
  );

  itaf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (push),
    .wr_job (front_job),
    .full   (full),
    .rd     (q_pop),
    .rd_job (back_job),
    .empty  (q_empty)
  );

  itaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

>>> sv/itaf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module itaf_checker (
  input var logic                 clk,
  input var logic                 rst,
  input var logic                 push,
  input var logic                 full,
  input var logic                 empty,
  input var logic                 pop,
  input var itaf_pkg::out_word_t  result
);

  // no word comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // the queue fills only on a push
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // only sign, digits and hex letters appear
  a_charset: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.character == itaf_pkg::CH_MINUS ||
                (result.character >= 8'h30 && result.character <= 8'h39) ||
                (result.character >= 8'h41 && result.character <= 8'h46) ||
                (result.character >= 8'h61 && result.character <= 8'h66)))
    else $error("bad character");

  // a sign never ends the text
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.character == itaf_pkg::CH_MINUS) |-> !result.last)
    else $error("sign marked last");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire

>>> tb/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 129;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;

  class char_scoreboard;
    itaf_pkg::out_word_t expected_chars[$];
    int mismatches;
    int values_noted;
    int chars_checked;

    // builds the expected text of one value and queues its characters
    function void note_value(itaf_pkg::in_word_t w);
      logic [31:0] mag;
      logic [3:0] nib;
      logic [7:0] text[$];
      logic [7:0] digits[$];
      itaf_pkg::out_word_t ch;
      begin
        values_noted++;
        if (w.operation == itaf_pkg::OP_HEXL || w.operation == itaf_pkg::OP_HEXU) begin
          for (int i = 7; i >= 0; i--) begin
            nib = w.value[i*4 +: 4];
            if (nib < 4'd10) begin
              text.push_back(ASCII_ZERO + 8'(nib));
            end else begin
              text.push_back((w.operation == itaf_pkg::OP_HEXU ? ASCII_UPPER_A
                                                               : ASCII_LOWER_A)
                             + 8'(nib) - 8'd10);
            end
          end
        end else begin
          mag = w.value;
          if (w.operation == itaf_pkg::OP_SDEC && w.value[31]) begin
            text.push_back(ASCII_MINUS);
            mag = 32'd0 - w.value;
          end
          do begin
            digits.push_front(ASCII_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
          end while (mag != 32'd0);
          foreach (digits[i]) text.push_back(digits[i]);
        end
        foreach (text[i]) begin
          ch.character = text[i];
          ch.last = (i == text.size() - 1);
          expected_chars.push_back(ch);
        end
      end
    endfunction

    function void check_char(itaf_pkg::out_word_t got);
      itaf_pkg::out_word_t exp_ch;
      begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result word: character %h last %b", got.character, got.last);
          mismatches++;
        end else begin
          exp_ch = expected_chars.pop_front();
          chars_checked++;
          if (got.character !== exp_ch.character) begin
            $error("character mismatch: expected %h, actual %h", exp_ch.character,
                   got.character);
            mismatches++;
          end
          if (got.last !== exp_ch.last) begin
            $error("last mismatch: expected %b, actual %b", exp_ch.last, got.last);
            mismatches++;
          end
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  itaf_pkg::in_word_t item = '0;
  itaf_pkg::out_word_t result;

  char_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;

  integer_to_ascii_formatter dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // input/output monitors and random pop
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst) begin
      if (push && !full) sb.note_value(item);
      if (pop && !empty) sb.check_char(result);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_value(input itaf_pkg::op_t op, input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{operation: op, value: v};
    do @(posedge clk); while (full);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] p;
    begin
      p = 32'd1;
      case ($urandom_range(5))
        1: random_value = 32'($urandom_range(0, 20));
        2: random_value = $urandom >> $urandom_range(31);
        3: begin
          // around a power of ten, where the digit count changes
          repeat ($urandom_range(9)) p = p * 32'd10;
          random_value = p + 32'($urandom_range(0, 2)) - 32'd1;
        end
        4: begin
          if ($urandom_range(1)) begin
            random_value = 32'd0 - 32'($urandom_range(0, 20));
          end else begin
            random_value = 32'h8000_0000 | $urandom;
          end
        end
        default: random_value = $urandom;
      endcase
    end
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_value(itaf_pkg::OP_UDEC, 32'd0);
    send_value(itaf_pkg::OP_SDEC, 32'd0);
    send_value(itaf_pkg::OP_HEXL, 32'd0);
    send_value(itaf_pkg::OP_HEXU, 32'd0);
    send_value(itaf_pkg::OP_UDEC, 32'hffff_ffff);
    send_value(itaf_pkg::OP_SDEC, 32'hffff_ffff);
    send_value(itaf_pkg::OP_HEXL, 32'hffff_ffff);
    send_value(itaf_pkg::OP_HEXU, 32'hffff_ffff);
    send_value(itaf_pkg::OP_SDEC, 32'h8000_0000);
    send_value(itaf_pkg::OP_UDEC, 32'h8000_0000);
    send_value(itaf_pkg::OP_SDEC, 32'h7fff_ffff);
    send_value(itaf_pkg::OP_UDEC, 32'd1);
    send_value(itaf_pkg::OP_UDEC, 32'd9);
    send_value(itaf_pkg::OP_UDEC, 32'd10);
    send_value(itaf_pkg::OP_SDEC, 32'd99);
    send_value(itaf_pkg::OP_UDEC, 32'd100);
    send_value(itaf_pkg::OP_UDEC, 32'd999999999);
    send_value(itaf_pkg::OP_UDEC, 32'd1000000000);
    send_value(itaf_pkg::OP_SDEC, 32'hc465_3600);
    send_value(itaf_pkg::OP_HEXL, 32'h0123_4567);
    send_value(itaf_pkg::OP_HEXL, 32'h89ab_cdef);
    send_value(itaf_pkg::OP_HEXU, 32'h0123_4567);
    send_value(itaf_pkg::OP_HEXU, 32'h89ab_cdef);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 30 : 0;
      repeat (RANDOM_PER_PHASE) begin
        send_value(itaf_pkg::op_t'($urandom_range(3)), random_value());
      end
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("formatted %0d values in all four conversions, %0d characters checked",
             sb.values_noted, sb.chars_checked);
    $display("idling covered sender-heavy, receiver-heavy and back-to-back traffic");
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
